// ----- rtl/sfld_pkg.sv -----
// Shared types and constants for the scanner frame and line deframer.
// No dependencies; imported by every module of the block.
package sfld_pkg;

    localparam int LINE_MAX  = 1024;
    localparam int OUT_LIMIT = 256;
    localparam int LINE_W    = $clog2(LINE_MAX + 1);
    localparam int PCT_W     = 7;
    localparam int PROD_W    = LINE_W + PCT_W;
    localparam int LEN_CAP   = (OUT_LIMIT - 1 < 255) ? OUT_LIMIT - 1 : 255;

    localparam logic [7:0] START_BYTE = 8'h03;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    localparam logic [2:0] KIND_TEXT     = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
    localparam logic [2:0] KIND_ACCEPTED = 3'd2;
    localparam logic [2:0] KIND_REJECTED = 3'd3;
    localparam logic [2:0] KIND_ABANDON  = 3'd4;

    localparam logic [0:0] CFG_PRINTABLE_PERCENT = 1'd0;
    localparam logic [0:0] CFG_MAX_PAYLOAD       = 1'd1;

    localparam logic [PCT_W-1:0] PCT_RESET     = PCT_W'(80);
    localparam logic [7:0]       MAXPAY_RESET  = 8'd250;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [7:0] line_length;
        logic       last;
    } result_t;

endpackage

// ----- rtl/scanner_frame_and_line_deframer.sv -----
// Top level of the scanner frame and line deframer.
// Depends on sfld_pkg, sfld_frame, sfld_line and sfld_outreg.
//
//   channel  dir  handshake              payload
//   s_       in   s_valid / s_ready      s_data_byte
//   m_       out  m_valid / m_ready      m_kind, m_out_byte, m_line_length, m_last
//   cfg_     in   cfg_wr_en              cfg_index, cfg_wr_data
//
// One request per cycle while s_ready is high; any result of a request is registered and appears in the cycle after it.
// All decoding runs in the accept cycle ahead of the single result register.
// s_ready drops only while a result is held and m_ready is low.
// Reset clears mode, line counters and the result valid; registers reload
// to 80 percent and a 250 byte payload limit.
module scanner_frame_and_line_deframer import sfld_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic [7:0] m_line_length,
    output logic       m_last,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wr_data
);

    logic [PCT_W-1:0] pct_reg;
    logic [7:0]       max_payload_reg;
    logic             accept, line_step;
    result_t          line_res, res;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_reg         <= PCT_RESET;
            max_payload_reg <= MAXPAY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PRINTABLE_PERCENT: pct_reg <= cfg_wr_data[PCT_W-1:0];
                CFG_MAX_PAYLOAD:       max_payload_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    sfld_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_data_byte),
        .max_payload (max_payload_reg),
        .line_res    (line_res),
        .line_step   (line_step),
        .res         (res)
    );

    sfld_line u_line (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (line_step),
        .data_byte         (s_data_byte),
        .printable_percent (pct_reg),
        .res               (line_res)
    );

    sfld_outreg u_outreg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .res           (res),
        .m_ready       (m_ready),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_line_length (m_line_length),
        .m_last        (m_last)
    );

endmodule

// ----- rtl/sfld_line.sv -----
// Text line tracker: counters for the pending line and its verdict.
// Depends on sfld_pkg.
module sfld_line import sfld_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic [PCT_W-1:0] printable_percent,
    output result_t          res
);

    logic [LINE_W-1:0] line_count_reg, line_count_next;
    logic [LINE_W-1:0] printable_count_reg, printable_count_next;
    logic [LINE_W-1:0] trailing_spaces_reg, trailing_spaces_next;
    logic [LINE_W-1:0] trim_len, trim_print;
    logic [PROD_W-1:0] lhs, rhs;
    logic              is_term, is_print;

    assign trim_len   = line_count_reg - trailing_spaces_reg;
    assign trim_print = printable_count_reg - trailing_spaces_reg;
    assign lhs        = PROD_W'(trim_print) * PROD_W'(100);
    assign rhs        = PROD_W'(printable_percent) * PROD_W'(trim_len);

    always_comb begin
        is_term  = data_byte inside {CHAR_LF, CHAR_CR, CHAR_TAB};
        is_print = data_byte inside {[CHAR_SPACE:CHAR_TILDE]};
        line_count_next      = line_count_reg;
        printable_count_next = printable_count_reg;
        trailing_spaces_next = trailing_spaces_reg;
        res = '0;
        if (data_byte == START_BYTE) begin
            line_count_next      = '0;
            printable_count_next = '0;
            trailing_spaces_next = '0;
            if (line_count_reg != '0) begin
                res.valid = 1'b1;
                res.kind  = KIND_ABANDON;
            end
        end else if (is_term) begin
            if (line_count_reg != '0) begin
                line_count_next      = '0;
                printable_count_next = '0;
                trailing_spaces_next = '0;
                res.valid = 1'b1;
                if (trim_len == '0 || lhs < rhs) begin
                    res.kind = KIND_REJECTED;
                end else begin
                    res.kind = KIND_ACCEPTED;
                    if (32'(trim_len) > LEN_CAP) begin
                        res.line_length = 8'(LEN_CAP);
                    end else begin
                        res.line_length = 8'(trim_len);
                    end
                end
            end
        end else if (32'(line_count_reg) >= LINE_MAX) begin
            line_count_next      = '0;
            printable_count_next = '0;
            trailing_spaces_next = '0;
            res.valid = 1'b1;
            res.kind  = KIND_ABANDON;
        end else begin
            line_count_next = line_count_reg + LINE_W'(1);
            if (is_print) begin
                printable_count_next = printable_count_reg + LINE_W'(1);
            end
            if (data_byte == CHAR_SPACE) begin
                trailing_spaces_next = trailing_spaces_reg + LINE_W'(1);
            end else begin
                trailing_spaces_next = '0;
            end
            res.valid    = 1'b1;
            res.kind     = KIND_TEXT;
            res.out_byte = data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg      <= '0;
            printable_count_reg <= '0;
            trailing_spaces_reg <= '0;
        end else if (step) begin
            line_count_reg      <= line_count_next;
            printable_count_reg <= printable_count_next;
            trailing_spaces_reg <= trailing_spaces_next;
        end
    end

endmodule

// ----- rtl/sfld_frame.sv -----
// Frame mode control: start byte, length byte and payload countdown.
// Depends on sfld_pkg; steers text bytes to the line tracker.
module sfld_frame import sfld_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic [7:0] max_payload,
    input  result_t    line_res,
    output logic       line_step,
    output result_t    res
);

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_LEN  = 2'd1;
    localparam logic [1:0] MODE_PAY  = 2'd2;

    logic [1:0] mode_reg, mode_next;
    logic [7:0] payload_left_reg, payload_left_next;
    logic       text_sel;

    always_comb begin
        mode_next         = mode_reg;
        payload_left_next = payload_left_reg;
        text_sel          = 1'b1;
        res               = line_res;
        case (mode_reg)
            MODE_LEN: begin
                if (data_byte == 8'd0 || data_byte > max_payload) begin
                    mode_next = (data_byte == START_BYTE) ? MODE_LEN : MODE_TEXT;
                end else begin
                    text_sel          = 1'b0;
                    payload_left_next = data_byte;
                    mode_next         = MODE_PAY;
                    res               = '0;
                end
            end
            MODE_PAY: begin
                text_sel = 1'b0;
                if (payload_left_reg != 8'd0) begin
                    payload_left_next = payload_left_reg - 8'd1;
                end
                res          = '0;
                res.valid    = 1'b1;
                res.kind     = KIND_PAYLOAD;
                res.out_byte = data_byte;
                res.last     = (payload_left_next == 8'd0);
                mode_next    = res.last ? MODE_TEXT : MODE_PAY;
            end
            default: begin
                mode_next = (data_byte == START_BYTE) ? MODE_LEN : MODE_TEXT;
            end
        endcase
    end

    assign line_step = accept && text_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_TEXT;
            payload_left_reg <= 8'd0;
        end else if (accept) begin
            mode_reg         <= mode_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

// ----- rtl/sfld_outreg.sv -----
// Result register with backpressure toward the input side.
// Depends on sfld_pkg.
module sfld_outreg import sfld_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  result_t    res,
    input  logic       m_ready,
    output logic       in_ready,
    output logic       m_valid,
    output logic [2:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic [7:0] m_line_length,
    output logic       m_last
);

    logic       valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] byte_reg, len_reg;
    logic       last_reg;

    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept && res.valid) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res.valid) begin
            kind_reg <= res.kind;
            byte_reg <= res.out_byte;
            len_reg  <= res.line_length;
            last_reg <= res.last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_kind        = kind_reg;
    assign m_out_byte    = byte_reg;
    assign m_line_length = len_reg;
    assign m_last        = last_reg;

endmodule

// ----- rtl/sfld_checker.sv -----
// Port-level checks for the deframer result channel, bound to the top level.
// Depends on sfld_pkg and scanner_frame_and_line_deframer.
module sfld_checker import sfld_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic [7:0] m_out_byte,
    input logic [7:0] m_line_length,
    input logic       m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_out_byte))
        else $error("stalled result changed");

    a_last_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_kind == KIND_PAYLOAD)
        else $error("last mark outside payload");

    a_verdict_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_ACCEPTED || m_kind == KIND_REJECTED ||
                    m_kind == KIND_ABANDON) |-> m_out_byte == 8'd0)
        else $error("verdict carries a byte");

    a_length_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_ACCEPTED |-> m_line_length == 8'd0)
        else $error("line length on non-accept result");

endmodule

bind scanner_frame_and_line_deframer sfld_checker u_sfld_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_out_byte    (m_out_byte),
    .m_line_length (m_line_length),
    .m_last        (m_last)
);

// ----- tb/tb.sv -----
// Self-checking testbench for scanner_frame_and_line_deframer: random and directed byte
// streams, randomly stalled on both channels, are checked against an in-bench predictor.
// Depends on sfld_pkg and the block's RTL; needs nothing else.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfld_pkg::*;

    localparam int STALL_MAX      = 13;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_MAX     = 10;

    typedef enum logic [1:0] {
        SCAN_TEXT = 2'd0,
        SCAN_LEN  = 2'd1,
        SCAN_PAY  = 2'd2
    } scan_mode_e;

    typedef enum int {
        END_CR,
        END_LF,
        END_TAB,
        END_CRLF,
        END_START,
        END_NONE
    } line_end_e;

    class deframe_scoreboard;
        int unsigned min_pct;
        int unsigned max_len;
        scan_mode_e  mode;
        int unsigned pay_left;
        int unsigned line_cnt;
        int unsigned print_cnt;
        int unsigned trail_sp;
        result_t     due_q[$];
        int          mismatches;

        function new();
            min_pct    = PCT_RESET;
            max_len    = MAXPAY_RESET;
            mode       = SCAN_TEXT;
            pay_left   = 0;
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_cnt  = 0;
            print_cnt = 0;
            trail_sp  = 0;
        endfunction

        function void write_reg(input logic [0:0] idx, input logic [7:0] data);
            if (idx == CFG_PRINTABLE_PERCENT) begin
                min_pct = data[6:0];
            end else begin
                max_len = data;
            end
        endfunction

        function void add_result(input logic [2:0] kind, input logic [7:0] ob,
                                 input logic [7:0] len, input logic lst);
            result_t r;
            r.valid       = 1'b1;
            r.kind        = kind;
            r.out_byte    = ob;
            r.line_length = len;
            r.last        = lst;
            due_q.push_back(r);
        endfunction

        function void line_byte(input logic [7:0] b);
            int unsigned n;
            int unsigned p;
            if (b == START_BYTE) begin
                mode = SCAN_LEN;
                if (line_cnt != 0) begin
                    add_result(KIND_ABANDON, 8'h00, 8'h00, 1'b0);
                end
                clear_line();
                return;
            end
            if (b == CHAR_LF || b == CHAR_CR || b == CHAR_TAB) begin
                if (line_cnt == 0) begin
                    return;
                end
                n = line_cnt - trail_sp;
                p = print_cnt - trail_sp;
                clear_line();
                if (n == 0 || p * 100 < min_pct * n) begin
                    add_result(KIND_REJECTED, 8'h00, 8'h00, 1'b0);
                end else begin
                    add_result(KIND_ACCEPTED, 8'h00, 8'(n > LEN_CAP ? LEN_CAP : n), 1'b0);
                end
                return;
            end
            if (line_cnt >= LINE_MAX) begin
                clear_line();
                add_result(KIND_ABANDON, 8'h00, 8'h00, 1'b0);
                return;
            end
            line_cnt++;
            if (b >= CHAR_SPACE && b <= CHAR_TILDE) begin
                print_cnt++;
            end
            if (b == CHAR_SPACE) begin
                trail_sp++;
            end else begin
                trail_sp = 0;
            end
            add_result(KIND_TEXT, b, 8'h00, 1'b0);
        endfunction

        function void note_byte(input logic [7:0] b);
            logic lst;
            case (mode)
                SCAN_LEN: begin
                    if (b == 0 || b > max_len) begin
                        mode = SCAN_TEXT;
                        line_byte(b);
                    end else begin
                        pay_left = b;
                        mode     = SCAN_PAY;
                    end
                end
                SCAN_PAY: begin
                    if (pay_left > 0) begin
                        pay_left--;
                    end
                    lst = (pay_left == 0);
                    if (lst) begin
                        mode = SCAN_TEXT;
                    end
                    add_result(KIND_PAYLOAD, b, 8'h00, lst);
                end
                default: begin
                    mode = SCAN_TEXT;
                    line_byte(b);
                end
            endcase
        endfunction

        function void check_result(input logic [2:0] kind, input logic [7:0] ob,
                                   input logic [7:0] len, input logic lst);
            result_t want;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: kind %0d byte %02h len %0d last %0d",
                             kind, ob, len, lst);
                end
                return;
            end
            want = due_q.pop_front();
            if (want.kind !== kind || want.out_byte !== ob ||
                want.line_length !== len || want.last !== lst) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display({"mismatch: expected kind %0d byte %02h len %0d last %0d,",
                              " got kind %0d byte %02h len %0d last %0d"},
                             want.kind, want.out_byte, want.line_length, want.last,
                             kind, ob, len, lst);
                end
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte   = 8'h00;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_out_byte;
    logic [7:0] m_line_length;
    logic       m_last;
    logic       cfg_wr_en     = 1'b0;
    logic [0:0] cfg_index     = CFG_PRINTABLE_PERCENT;
    logic [7:0] cfg_wr_data   = 8'h00;

    deframe_scoreboard sb;
    bit          rush_in  = 1'b0;
    bit          rush_out = 1'b0;
    int unsigned sent     = 0;
    int          idle_cycles = 0;

    scanner_frame_and_line_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_byte    (m_out_byte),
        .m_line_length (m_line_length),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        bit          took;
        gap = rush_in ? 0 : $urandom_range(0, STALL_MAX);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        sb.note_byte(value);
        sent++;
    endtask

    task automatic send_frame(input int unsigned len);
        send_byte(START_BYTE);
        send_byte(8'(len));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] line_char(input int unsigned np_pct);
        logic [7:0] c;
        if ($urandom_range(0, 99) >= np_pct) begin
            return 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CHAR_SPACE && c <= CHAR_TILDE) || c == START_BYTE ||
                   c == CHAR_CR || c == CHAR_LF || c == CHAR_TAB);
        return c;
    endfunction

    task automatic send_line(input int unsigned body, input int unsigned np_pct,
                             input int unsigned tail, input line_end_e ending);
        repeat (body) send_byte(line_char(np_pct));
        repeat (tail) send_byte(CHAR_SPACE);
        case (ending)
            END_CR:    send_byte(CHAR_CR);
            END_LF:    send_byte(CHAR_LF);
            END_TAB:   send_byte(CHAR_TAB);
            END_CRLF: begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            END_START: send_byte(START_BYTE);
            default: ;
        endcase
    endtask

    task automatic random_episode();
        int unsigned pick;
        int unsigned cap;
        int unsigned len;
        int unsigned np;
        pick     = $urandom_range(0, 99);
        rush_in  = ($urandom_range(0, 4) == 0);
        rush_out = ($urandom_range(0, 4) == 0);
        cap      = sb.max_len;
        if (pick < 40) begin
            if (cap == 0) begin
                send_byte(START_BYTE);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(1, cap)
                                                   : $urandom_range(1, cap < 8 ? cap : 8);
                send_frame(len);
            end
        end else if (pick < 50) begin
            send_byte(START_BYTE);
            if (cap == 255 || $urandom_range(0, 1) == 0) begin
                send_byte(8'h00);
            end else begin
                send_byte(8'($urandom_range(cap + 1, 255)));
            end
        end else if (pick < 88) begin
            np = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
            send_line($urandom_range(0, 20), np,
                      ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0,
                      line_end_e'($urandom_range(END_CR, END_NONE)));
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned target;
        target = sent + count;
        while (sent < target) random_episode();
    endtask

    // drain: no request in flight, no result outstanding
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [7:0] pct_data, input logic [7:0] len_data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_PRINTABLE_PERCENT;
        cfg_wr_data <= pct_data;
        @(posedge aclk);
        sb.write_reg(CFG_PRINTABLE_PERCENT, pct_data);
        cfg_index   <= CFG_MAX_PAYLOAD;
        cfg_wr_data <= len_data;
        @(posedge aclk);
        sb.write_reg(CFG_MAX_PAYLOAD, len_data);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : result_sink
        int unsigned stall;
        bit          hit;
        logic [2:0]  k;
        logic [7:0]  ob;
        logic [7:0]  ll;
        logic        lst;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = rush_out ? 0 : $urandom_range(0, STALL_MAX);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                hit = m_valid;
                k   = m_kind;
                ob  = m_out_byte;
                ll  = m_line_length;
                lst = m_last;
                @(posedge aclk);
            end while (!hit);
            sb.check_result(k, ob, ll, lst);
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: 80 percent, 250 byte payload limit
        send_byte(START_BYTE);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(START_BYTE);
        send_byte(8'h00);
        send_byte(START_BYTE);
        send_byte(8'd251);
        send_byte(CHAR_TAB);
        send_byte(8'h41);
        send_byte(START_BYTE);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(CHAR_SPACE);
        send_byte(CHAR_SPACE);
        send_byte(CHAR_LF);
        send_byte(CHAR_TILDE);
        send_byte(CHAR_SPACE);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'h7F);
        send_byte(8'h1F);
        send_byte(CHAR_CR);
        send_line(256, 0, 0, END_LF);
        run_random(30);

        settle();
        write_regs(8'd0, 8'd1);
        run_random(20);

        settle();
        write_regs(8'd100, 8'hFF);
        run_random(20);

        // bit 7 of the percent write is dropped: 101 percent
        settle();
        write_regs(8'hE5, 8'h00);
        run_random(15);

        settle();
        write_regs(8'h7F, 8'h80);
        run_random(15);

        settle();
        write_regs(8'd50, 8'd12);
        send_line(LINE_MAX, 0, 0, END_NONE);
        send_line(2, 0, 0, END_CR);
        run_random(20);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
